[sv/fdhc_pkg.sv]
// Shared types and constants for the fan duty hysteresis curve block.
package fdhc_pkg;

  // Fan modes as reported on the result port
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RAMP = 2'd1;
  localparam logic [1:0] MODE_MAX  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FLOOR   = 2'd0;
  localparam logic [1:0] REG_CEILING = 2'd1;
  localparam logic [1:0] REG_HYST    = 2'd2;
  localparam logic [1:0] REG_MIN     = 2'd3;

  // Full drive in Q1.12
  localparam logic [12:0] DUTY_FULL = 13'd4096;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // Operands handed to the serial ramp unit: n < d, quotient of n*k/d fits 12 bits
  typedef struct packed {
    logic [15:0] num;
    logic [15:0] den;
    logic [12:0] span;
  } ramp_req_t;

endpackage

[sv/fdhc_ramp_unit.sv]
// Bit-serial multiply then restoring divide: quot = (num * span) / den.
module fdhc_ramp_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fdhc_pkg::ramp_req_t req_i,
  output logic              done_o,
  output logic [11:0]       quot_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [28:0] acc_q, acc_d;
  logic [12:0] span_q, span_d;
  logic [15:0] num_q, num_d;
  logic [15:0] den_q, den_d;
  logic [15:0] rem_q, rem_d;
  logic [11:0] quot_q, quot_d;

  logic [28:0] mul_sum;
  logic [16:0] trial;
  logic        fits;

  // One multiplier bit per cycle, MSB first; one quotient bit per cycle
  always_comb begin
    mul_sum = {acc_q[27:0], 1'b0} + (span_q[12] ? {13'd0, num_q} : 29'd0);
    trial   = {rem_q, acc_q[11]};
    fits    = trial >= {1'b0, den_q};
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    span_d  = span_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          num_d   = req_i.num;
          den_d   = req_i.den;
          span_d  = req_i.span;
          acc_d   = '0;
          cnt_d   = 4'd12;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        acc_d  = mul_sum;
        span_d = {span_q[11:0], 1'b0};
        if (cnt_q == '0) begin
          // product < den * 4096, so the upper part is already below den
          rem_d   = mul_sum[27:12];
          cnt_d   = 4'd11;
          phase_d = PH_DIV;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      PH_DIV: begin
        acc_d[11:0] = {acc_q[10:0], 1'b0};
        rem_d       = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        quot_d      = {quot_q[10:0], fits};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    span_q <= span_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/fan_duty_hysteresis_curve_core.sv]
// Fan duty controller: hysteresis mode machine and linear temperature-to-duty curve.
// Each input word either stores a temperature (cmd 0) or polls the stored one (cmd 1),
// and yields exactly one result word: duty (Q1.12, 4096 full), fan mode and no_sample.
// Until the first sample arrives the duty is full and the mode is not updated. A word
// is taken only while the block is free. A ramping word that needs the division goes
// through evaluate, prepare, the bit-serial unit (13 multiply steps, 12 divide steps
// and its done flag), done and idle before the next word is accepted. Idle and max
// words, and ramping words clamped at either end of the curve, skip the bit-serial
// unit; words before the first sample skip prepare as well. The output register lets
// the next word be accepted while a result still waits; a word that finishes while
// that result is still stalled holds in its done step. Configuration registers are
// written through a port that is always ready.
module fan_duty_hysteresis_curve_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [15:0] in_temperature_i,
  // Result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] out_duty_o,
  output logic [1:0]  out_fan_mode_o,
  output logic        out_no_sample_o,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_RAMP = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [15:0] floor_q, ceiling_q;
  logic [11:0] hyst_q;
  logic [12:0] min_q;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] held_q;
  logic        awaiting_q;
  logic signed [16:0] diff_n_q, diff_d_q;
  logic [12:0] res_duty_q, res_duty_d;
  logic        res_ns_q, res_ns_d;
  logic        out_valid_q;
  logic [12:0] out_duty_q;
  logic [1:0]  out_mode_q;
  logic        out_ns_q;

  logic        in_acc, out_free;
  logic [12:0] lo_duty;
  logic signed [17:0] t_ext, floor_ext, ceil_ext, floor_lo, ceil_lo;
  logic signed [16:0] n_f, d_f;
  logic        ramp_start, ramp_done;
  logic [11:0] ramp_quot;
  fdhc_pkg::ramp_req_t ramp_req;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign lo_duty     = (min_q > fdhc_pkg::DUTY_FULL) ? fdhc_pkg::DUTY_FULL : min_q;

  // Thresholds without wrap
  always_comb begin
    t_ext     = 18'(signed'(held_q));
    floor_ext = 18'(signed'(floor_q));
    ceil_ext  = 18'(signed'(ceiling_q));
    floor_lo  = floor_ext - $signed({6'd0, hyst_q});
    ceil_lo   = ceil_ext - $signed({6'd0, hyst_q});
  end

  // Mode transitions
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      fdhc_pkg::MODE_IDLE: if (t_ext >= floor_ext) mode_d = fdhc_pkg::MODE_RAMP;
      fdhc_pkg::MODE_RAMP: begin
        if (t_ext >= ceil_ext) mode_d = fdhc_pkg::MODE_MAX;
        else if (t_ext < floor_lo) mode_d = fdhc_pkg::MODE_IDLE;
      end
      fdhc_pkg::MODE_MAX: if (t_ext < ceil_lo) mode_d = fdhc_pkg::MODE_RAMP;
      default: mode_d = mode_q;
    endcase
  end

  // Ramp operands with the span direction normalized
  always_comb begin
    n_f = diff_d_q[16] ? -diff_n_q : diff_n_q;
    d_f = diff_d_q[16] ? -diff_d_q : diff_d_q;
    ramp_req.num  = n_f[15:0];
    ramp_req.den  = d_f[15:0];
    ramp_req.span = fdhc_pkg::DUTY_FULL - lo_duty;
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    res_duty_d = res_duty_q;
    res_ns_d   = res_ns_q;
    ramp_start = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EVAL;
      ST_EVAL: begin
        if (awaiting_q) begin
          res_duty_d = fdhc_pkg::DUTY_FULL;
          res_ns_d   = 1'b1;
          state_d    = ST_DONE;
        end else begin
          res_ns_d = 1'b0;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        priority if (mode_q == fdhc_pkg::MODE_IDLE) begin
          res_duty_d = lo_duty;
          state_d    = ST_DONE;
        end else if (mode_q == fdhc_pkg::MODE_MAX) begin
          res_duty_d = fdhc_pkg::DUTY_FULL;
          state_d    = ST_DONE;
        end else if (d_f == '0 || n_f <= 17'sd0) begin
          res_duty_d = lo_duty;
          state_d    = ST_DONE;
        end else if (n_f >= d_f) begin
          res_duty_d = fdhc_pkg::DUTY_FULL;
          state_d    = ST_DONE;
        end else begin
          ramp_start = 1'b1;
          state_d    = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (ramp_done) begin
          res_duty_d = lo_duty + {1'b0, ramp_quot};
          state_d    = ST_DONE;
        end
      end
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      floor_q     <= 16'd640;
      ceiling_q   <= 16'd1120;
      hyst_q      <= 12'd32;
      min_q       <= 13'd1229;
      mode_q      <= fdhc_pkg::MODE_IDLE;
      held_q      <= '0;
      awaiting_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fdhc_pkg::REG_FLOOR:   floor_q   <= cfg_data_i;
          fdhc_pkg::REG_CEILING: ceiling_q <= cfg_data_i;
          fdhc_pkg::REG_HYST:    hyst_q    <= cfg_data_i[11:0];
          fdhc_pkg::REG_MIN:     min_q     <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      // Sample capture
      if (in_acc && in_cmd_i == fdhc_pkg::CMD_SAMPLE) begin
        held_q     <= in_temperature_i;
        awaiting_q <= 1'b0;
      end
      if (state_q == ST_EVAL && !awaiting_q) mode_q <= mode_d;
      // Output register
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    res_duty_q <= res_duty_d;
    res_ns_q   <= res_ns_d;
    if (state_q == ST_EVAL) begin
      diff_n_q <= 17'(signed'(held_q)) - 17'(signed'(floor_q));
      diff_d_q <= 17'(signed'(ceiling_q)) - 17'(signed'(floor_q));
    end
    if (state_q == ST_DONE && out_free) begin
      out_duty_q <= res_duty_q;
      out_mode_q <= mode_q;
      out_ns_q   <= res_ns_q;
    end
  end

  fdhc_ramp_unit u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ramp_start),
    .req_i   (ramp_req),
    .done_o  (ramp_done),
    .quot_o  (ramp_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign out_duty_o      = out_duty_q;
  assign out_fan_mode_o  = out_mode_q;
  assign out_no_sample_o = out_ns_q;

  // Checks
  a_full_before_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_no_sample_o |-> out_duty_o == fdhc_pkg::DUTY_FULL)
    else $error("duty not full before first sample");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_duty_o <= fdhc_pkg::DUTY_FULL)
    else $error("duty above full");

  a_max_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_no_sample_o && out_fan_mode_o == fdhc_pkg::MODE_MAX
    |-> out_duty_o == fdhc_pkg::DUTY_FULL)
    else $error("max mode without full duty");

  a_done_in_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_done |-> state_q == ST_RAMP)
    else $error("ramp unit finished outside ramp wait");

endmodule

[tb/fan_duty_hysteresis_curve_core_tb.sv]
// Self-checking testbench for the fan duty hysteresis curve core.
`timescale 1ns / 100ps

module fan_duty_hysteresis_curve_core_tb;

  // One result word as seen on the output port
  typedef struct {
    logic [12:0] duty;
    logic [1:0]  fan_mode;
    logic        no_sample;
  } fan_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_cmd;
  logic [15:0] in_temperature;
  logic        out_stall;
  logic        cfg_valid;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  wire         in_stall;
  wire         out_valid;
  wire  [12:0] out_duty;
  wire  [1:0]  out_fan_mode;
  wire         out_no_sample;
  wire         cfg_ready;

  // Shadow copy of the block's registers and state
  logic signed [15:0] floor_r    = 16'sd640;
  logic signed [15:0] ceil_r     = 16'sd1120;
  logic        [11:0] hyst_r     = 12'd32;
  logic        [12:0] min_r      = 13'd1229;
  logic        [1:0]  fan_mode_q = fdhc_pkg::MODE_IDLE;
  logic signed [15:0] held_temp  = 16'sd0;
  logic               awaiting_first = 1'b1;

  fan_result_t duty_q[$];
  int          fail_count = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  fan_duty_hysteresis_curve_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_cmd_i         (in_cmd),
    .in_temperature_i (in_temperature),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_duty_o       (out_duty),
    .out_fan_mode_o   (out_fan_mode),
    .out_no_sample_o  (out_no_sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mode machine and duty curve; updates the shadow state for one word
  function automatic fan_result_t predict_fan(logic cmd, logic [15:0] temp);
    fan_result_t res;
    int          t, f, c, h, lo;
    longint      num, den;
    if (cmd == fdhc_pkg::CMD_SAMPLE) begin
      held_temp      = temp;
      awaiting_first = 1'b0;
    end
    if (awaiting_first) begin
      res.duty      = fdhc_pkg::DUTY_FULL;
      res.fan_mode  = fan_mode_q;
      res.no_sample = 1'b1;
      return res;
    end
    t  = int'(held_temp);
    f  = int'(floor_r);
    c  = int'(ceil_r);
    h  = int'(hyst_r);
    lo = int'(min_r);
    if (lo > int'(fdhc_pkg::DUTY_FULL)) lo = int'(fdhc_pkg::DUTY_FULL);
    // thresholds in int so floor - hysteresis never wraps
    case (fan_mode_q)
      fdhc_pkg::MODE_IDLE: begin
        if (t >= f) fan_mode_q = fdhc_pkg::MODE_RAMP;
      end
      fdhc_pkg::MODE_RAMP: begin
        if (t >= c) fan_mode_q = fdhc_pkg::MODE_MAX;
        else if (t < f - h) fan_mode_q = fdhc_pkg::MODE_IDLE;
      end
      default: begin
        if (t < c - h) fan_mode_q = fdhc_pkg::MODE_RAMP;
      end
    endcase
    if (fan_mode_q == fdhc_pkg::MODE_IDLE) begin
      res.duty = lo[12:0];
    end else if (fan_mode_q == fdhc_pkg::MODE_MAX) begin
      res.duty = fdhc_pkg::DUTY_FULL;
    end else begin
      num = longint'(t - f);
      den = longint'(c - f);
      // inverted curve: flip both signs
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (den == 0 || num <= 0) res.duty = lo[12:0];
      else if (num >= den) res.duty = fdhc_pkg::DUTY_FULL;
      else res.duty = 13'(lo + (num * (int'(fdhc_pkg::DUTY_FULL) - lo)) / den);
    end
    res.no_sample = 1'b0;
    res.fan_mode  = fan_mode_q;
    return res;
  endfunction

  // Send one word; valid stays up for a back-to-back follower
  task automatic send_word(logic cmd, logic [15:0] temp);
    int gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_temperature <= temp;
    do @(posedge clk_i); while (in_stall);
    duty_q.push_back(predict_fan(cmd, temp));
  endtask

  // Register write; caller drops cfg_valid after the last one
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      fdhc_pkg::REG_FLOOR:   floor_r = data;
      fdhc_pkg::REG_CEILING: ceil_r  = data;
      fdhc_pkg::REG_HYST:    hyst_r  = data[11:0];
      default:               min_r   = data[12:0];
    endcase
  endtask

  task automatic wait_drained();
    while (duty_q.size() != 0) @(posedge clk_i);
  endtask

  // Polls before the first sample: full duty forced, mode left alone
  task automatic test_no_sample();
    send_word(fdhc_pkg::CMD_POLL, 16'h8000);
    send_word(fdhc_pkg::CMD_POLL, 16'h7FFF);
    send_word(fdhc_pkg::CMD_POLL, 16'h0000);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Walk the reset curve across every threshold and the temperature extremes
  task automatic test_hysteresis_walk();
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd639);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd640);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd609);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd607);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd880);
    send_word(fdhc_pkg::CMD_POLL, 16'h5A5A);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd1119);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd1120);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd1089);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'd1087);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'h7FFF);
    send_word(fdhc_pkg::CMD_POLL, 16'hA5A5);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'h8000);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'h8000);
    send_word(fdhc_pkg::CMD_SAMPLE, 16'h0000);
    in_valid <= 1'b0;
  endtask

  // Phases of random words, each under its own curve; corner curves first
  task automatic test_random_curve();
    logic [15:0] fl, ce, junk, temp;
    logic [11:0] hy;
    logic [12:0] mn;
    logic        cmd;
    int          f, c, h, lo_t, hi_t, v, span;
    for (int phase = 0; phase < 14; phase++) begin
      wait_drained();
      case (phase)
        0: begin fl = 16'd640;  ce = 16'd1120; hy = 12'd32;   mn = 13'd1229; end
        1: begin fl = 16'h8000; ce = 16'h7FFF; hy = 12'd4095; mn = 13'd0;    end
        2: begin fl = 16'h7FFF; ce = 16'h8000; hy = 12'd0;    mn = 13'd4096; end
        3: begin fl = 16'd100;  ce = 16'd100;  hy = 12'd10;   mn = 13'd8191; end
        4: begin fl = 16'd0;    ce = 16'd1;    hy = 12'd0;    mn = 13'd4095; end
        5: begin fl = 16'h8000; ce = 16'h8000; hy = 12'd4095; mn = 13'd1;    end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            fl = 16'($urandom_range(0, 65535));
            ce = 16'($urandom_range(0, 65535));
          end else begin
            f    = $urandom_range(0, 4000) - 2000;
            span = $urandom_range(0, 1600) - 100;
            fl   = 16'(f);
            ce   = 16'(f + span);
          end
          hy = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(0, 200));
          mn = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                           : 13'($urandom_range(0, 4096));
        end
      endcase
      // unused upper data bits carry noise
      junk = 16'($urandom);
      write_reg(fdhc_pkg::REG_FLOOR, fl);
      write_reg(fdhc_pkg::REG_CEILING, ce);
      write_reg(fdhc_pkg::REG_HYST, {junk[15:12], hy});
      write_reg(fdhc_pkg::REG_MIN, {junk[15:13], mn});
      cfg_valid <= 1'b0;
      tx_quiet = (phase % 4 == 3);
      rx_quiet = (phase % 5 == 4);
      f  = int'(floor_r);
      c  = int'(ceil_r);
      h  = int'(hyst_r);
      lo_t = ((f < c) ? f : c) - h - 40;
      hi_t = ((f > c) ? f : c) + 40;
      for (int k = 0; k < 100; k++) begin
        cmd = ($urandom_range(0, 4) == 0) ? fdhc_pkg::CMD_POLL : fdhc_pkg::CMD_SAMPLE;
        v = $urandom_range(0, 99);
        // mostly inside the curve window, often right at a threshold
        if (v < 60) begin
          v = lo_t + $urandom_range(0, hi_t - lo_t);
        end else if (v < 85) begin
          case ($urandom_range(0, 3))
            0: v = f;
            1: v = c;
            2: v = f - h;
            default: v = c - h;
          endcase
          v = v + $urandom_range(0, 4) - 2;
        end else begin
          v = $urandom_range(0, 65535) - 32768;
        end
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        temp = 16'(v);
        send_word(cmd, temp);
      end
      in_valid <= 1'b0;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Result-side backpressure
  initial begin : rx_stall_gen
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) hold--;
      else hold = rx_quiet ? 0 : idle_len();
      out_stall <= (hold > 0);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    fan_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (duty_q.size() == 0) begin
        $error("unexpected result word: duty %0d fan_mode %0d no_sample %0d",
               out_duty, out_fan_mode, out_no_sample);
        fail_count++;
      end else begin
        want = duty_q.pop_front();
        if (out_duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, out_duty);
          fail_count++;
        end
        if (out_fan_mode !== want.fan_mode) begin
          $error("fan_mode: expected %0d, got %0d", want.fan_mode, out_fan_mode);
          fail_count++;
        end
        if (out_no_sample !== want.no_sample) begin
          $error("no_sample: expected %0d, got %0d", want.no_sample, out_no_sample);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_valid       <= 1'b0;
    in_cmd         <= fdhc_pkg::CMD_SAMPLE;
    in_temperature <= 16'd0;
    cfg_valid      <= 1'b0;
    cfg_index      <= fdhc_pkg::REG_FLOOR;
    cfg_data       <= 16'd0;
    rst_ni         <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_no_sample();
    test_hysteresis_walk();
    test_random_curve();
    wait_drained();
    // catch any stray word after the last expected one
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && duty_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
